>>> design/tpu_pkg.sv
// Package for the tracker pattern unpacker: cell type, phase enum,
// register indexes and the fixed constants of the packed pattern format.
// No dependencies.
`default_nettype none

package tpu_pkg;

  localparam int MaxChannelsDef = 32;
  localparam int MaxRowsDef     = 256;
  localparam int QueueDepth     = 2;

  localparam int ByteW      = 8;
  localparam int MaskW      = 5;
  localparam int ChanOutW   = 5;
  localparam int RowOutW    = 8;
  localparam int ChanCountW = 6;
  localparam int RowCountW  = 9;
  localparam int CfgDataW   = 9;

  localparam int LeadFlagBit = 7;

  localparam logic [ByteW-1:0]      NoteOffCode     = 8'd97;
  localparam logic [ByteW-1:0]      NoteOffOut      = 8'd255;
  localparam logic [ByteW-1:0]      VolumeDefault   = 8'd255;
  localparam logic [MaskW-1:0]      MaskAfterNote   = 5'b11110;
  localparam logic [ChanCountW-1:0] ChanCountReset  = 6'd1;
  localparam logic [RowCountW-1:0]  RowCountReset   = 9'd64;

  typedef enum logic [0:0] {
    CFG_CHANNEL_COUNT = 1'b0,
    CFG_ROW_COUNT     = 1'b1
  } cfg_reg_e;

  typedef enum logic [0:0] {
    PH_LEAD   = 1'b0,
    PH_FIELDS = 1'b1
  } phase_e;

  typedef struct packed {
    logic [ByteW-1:0] note;
    logic [ByteW-1:0] instrument;
    logic [ByteW-1:0] volume;
    logic [ByteW-1:0] effect;
    logic [ByteW-1:0] effect_param;
  } cell_t;

endpackage

`default_nettype wire

>>> design/tpu_front.sv
// Front end: accepts pattern bytes, decodes lead and mask bytes and
// collects the fields of one cell. Uses tpu_pkg.
`default_nettype none

module tpu_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          byte_take_i,
  input  wire logic [7:0]    data_byte_i,
  output tpu_pkg::cell_t     cell_o,
  output logic               push_o
);
  import tpu_pkg::*;

  phase_e            phase_q, phase_d;
  logic [MaskW-1:0]  mask_q, mask_d;
  cell_t             cell_q, cell_d;
  logic [MaskW-1:0]  work_mask;
  logic [MaskW-1:0]  sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_LEAD;
      mask_q  <= '0;
    end else begin
      phase_q <= phase_d;
      mask_q  <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
  end

  always_comb begin
    phase_d   = phase_q;
    mask_d    = mask_q;
    cell_d    = cell_q;
    work_mask = mask_q;
    sel       = '0;
    push_o    = 1'b0;
    if (byte_take_i) begin
      unique case (phase_q)
        PH_LEAD: begin
          cell_d.note         = '0;
          cell_d.instrument   = '0;
          cell_d.volume       = VolumeDefault;
          cell_d.effect       = '0;
          cell_d.effect_param = '0;
          if (data_byte_i[LeadFlagBit]) begin
            work_mask = data_byte_i[MaskW-1:0];
          end else begin
            cell_d.note = data_byte_i;
            work_mask   = MaskAfterNote;
          end
        end
        PH_FIELDS: begin
          // lowest pending field takes the byte
          sel = mask_q & (~mask_q + MaskW'(1));
          if (sel[0]) cell_d.note         = data_byte_i;
          if (sel[1]) cell_d.instrument   = data_byte_i;
          if (sel[2]) cell_d.volume       = data_byte_i;
          if (sel[3]) cell_d.effect       = data_byte_i;
          if (sel[4]) cell_d.effect_param = data_byte_i;
          work_mask = mask_q & ~sel;
        end
        default: begin
          work_mask = mask_q;
        end
      endcase
      if (work_mask == '0) begin
        push_o  = 1'b1;
        phase_d = PH_LEAD;
        mask_d  = '0;
      end else begin
        phase_d = PH_FIELDS;
        mask_d  = work_mask;
      end
    end
  end

  always_comb begin
    cell_o = cell_d;
    if (cell_d.note == NoteOffCode) cell_o.note = NoteOffOut;
  end

endmodule

`default_nettype wire

>>> design/tpu_queue.sv
// Short flop-based queue of decoded cells between front and back end.
// Uses tpu_pkg for the cell type.
`default_nettype none

module tpu_queue #(
  parameter int DEPTH = tpu_pkg::QueueDepth
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  tpu_pkg::cell_t     push_cell_i,
  output logic               full_o,
  input  wire logic          pop_i,
  output logic               empty_o,
  output tpu_pkg::cell_t     pop_cell_o
);
  import tpu_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  cell_t          slot_q [DEPTH];
  logic [AW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]  count_q;

  assign full_o     = (count_q == CW'(DEPTH));
  assign empty_o    = (count_q == '0);
  assign pop_cell_o = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= push_cell_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

>>> design/tpu_back.sv
// Back end: tags each cell with channel and row, flags the last cell of
// the pattern and holds it in the output register. Uses tpu_pkg.
`default_nettype none

module tpu_back #(
  parameter int MAX_CHANNELS = tpu_pkg::MaxChannelsDef,
  parameter int MAX_ROWS     = tpu_pkg::MaxRowsDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic [tpu_pkg::ChanCountW-1:0]     channel_count_i,
  input  wire logic [tpu_pkg::RowCountW-1:0]      row_count_i,
  input  wire logic                               empty_i,
  input  tpu_pkg::cell_t                          cell_i,
  output logic                                    pop_o,
  output logic                                    cell_valid_o,
  input  wire logic                               cell_stall_i,
  output tpu_pkg::cell_t                          cell_o,
  output logic [tpu_pkg::ChanOutW-1:0]            channel_o,
  output logic [tpu_pkg::RowOutW-1:0]             row_o,
  output logic                                    last_cell_o
);
  import tpu_pkg::*;

  localparam int ChW = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int RwW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int ChCmpW = ChanCountW + 1;
  localparam int RwCmpW = RowCountW + 1;
  localparam logic [ChCmpW-1:0] ChMax = ChCmpW'(MAX_CHANNELS);
  localparam logic [RwCmpW-1:0] RwMax = RwCmpW'(MAX_ROWS);

  logic [ChW-1:0]    ch_q;
  logic [RwW-1:0]    row_q;
  logic              valid_q;
  cell_t             cell_q;
  logic [ChW-1:0]    ch_out_q;
  logic [RwW-1:0]    row_out_q;
  logic              last_q;

  logic [ChCmpW-1:0] chans;
  logic [RwCmpW-1:0] rows;
  logic              last_chan, last_row;

  // clamp registers to 1..MAX
  always_comb begin
    if (channel_count_i == '0) chans = ChCmpW'(1);
    else if (ChCmpW'(channel_count_i) > ChMax) chans = ChMax;
    else chans = ChCmpW'(channel_count_i);
    if (row_count_i == '0) rows = RwCmpW'(1);
    else if (RwCmpW'(row_count_i) > RwMax) rows = RwMax;
    else rows = RwCmpW'(row_count_i);
  end

  assign last_chan = (ChCmpW'(ch_q) + ChCmpW'(1)) >= chans;
  assign last_row  = (RwCmpW'(row_q) + RwCmpW'(1)) >= rows;
  assign pop_o     = !empty_i && (!valid_q || !cell_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q    <= '0;
      row_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        valid_q <= 1'b1;
        if (last_chan) begin
          ch_q  <= '0;
          row_q <= last_row ? '0 : row_q + RwW'(1);
        end else begin
          ch_q <= ch_q + ChW'(1);
        end
      end else if (!cell_stall_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cell_q    <= cell_i;
      ch_out_q  <= ch_q;
      row_out_q <= row_q;
      last_q    <= last_chan && last_row;
    end
  end

  assign cell_valid_o = valid_q;
  assign cell_o       = cell_q;
  assign channel_o    = ChanOutW'(ch_out_q);
  assign row_o        = RowOutW'(row_out_q);
  assign last_cell_o  = last_q;

endmodule

`default_nettype wire

>>> design/tracker_pattern_unpacker_unit.sv
// Tracker pattern unpacker: one packed pattern byte per cycle in, one cell out.
// The edge that takes a cell's final byte writes it to the cell queue; the back end
// loads it into the output register once that register is empty or its cell is taken.
// Throughput: one byte per cycle; a cell takes one to six bytes. The input stalls
// only while the two-entry queue is full behind a held output. Reset clears channel
// and row to zero, sets the channel count to 1 and the row count to 64; no clearing pass.
`default_nettype none

module tracker_pattern_unpacker_unit #(
  parameter int MAX_CHANNELS = tpu_pkg::MaxChannelsDef,
  parameter int MAX_ROWS     = tpu_pkg::MaxRowsDef
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          data_valid_i,
  output logic                               data_stall_o,
  input  wire logic [7:0]                    data_byte_i,
  output logic                               cell_valid_o,
  input  wire logic                          cell_stall_i,
  output logic [7:0]                         note_o,
  output logic [7:0]                         instrument_o,
  output logic [7:0]                         volume_o,
  output logic [7:0]                         effect_o,
  output logic [7:0]                         effect_param_o,
  output logic [4:0]                         channel_o,
  output logic [7:0]                         row_o,
  output logic                               last_cell_o,
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  tpu_pkg::cfg_reg_e                  cfg_index_i,
  input  wire logic [tpu_pkg::CfgDataW-1:0]  cfg_data_i
);
  import tpu_pkg::*;

  logic [ChanCountW-1:0] chan_count_q;
  logic [RowCountW-1:0]  row_count_q;
  logic                  queue_full, queue_empty, push, pop;
  cell_t                 front_cell, queue_cell, out_cell;

  assign cfg_ready_o  = 1'b1;
  assign data_stall_o = queue_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q <= ChanCountReset;
      row_count_q  <= RowCountReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_CHANNEL_COUNT: chan_count_q <= cfg_data_i[ChanCountW-1:0];
        CFG_ROW_COUNT:     row_count_q  <= cfg_data_i[RowCountW-1:0];
        default:           row_count_q  <= row_count_q;
      endcase
    end
  end

  tpu_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .byte_take_i (data_valid_i && !data_stall_o),
    .data_byte_i (data_byte_i),
    .cell_o      (front_cell),
    .push_o      (push)
  );

  tpu_queue #(
    .DEPTH (QueueDepth)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_cell_i (front_cell),
    .full_o      (queue_full),
    .pop_i       (pop),
    .empty_o     (queue_empty),
    .pop_cell_o  (queue_cell)
  );

  tpu_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .MAX_ROWS     (MAX_ROWS)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .channel_count_i (chan_count_q),
    .row_count_i     (row_count_q),
    .empty_i         (queue_empty),
    .cell_i          (queue_cell),
    .pop_o           (pop),
    .cell_valid_o    (cell_valid_o),
    .cell_stall_i    (cell_stall_i),
    .cell_o          (out_cell),
    .channel_o       (channel_o),
    .row_o           (row_o),
    .last_cell_o     (last_cell_o)
  );

  assign note_o         = out_cell.note;
  assign instrument_o   = out_cell.instrument;
  assign volume_o       = out_cell.volume;
  assign effect_o       = out_cell.effect;
  assign effect_param_o = out_cell.effect_param;

endmodule

`default_nettype wire

>>> verif/pattern_cell_checker.sv
// Cell checker for tracker_pattern_unpacker_unit: follows the byte, cell and register
// channels, rebuilds the expected cells and compares each delivered cell field by field.
// Depends on tpu_pkg for the cell layout, register indexes and format constants.
module pattern_cell_checker #(
  parameter int MAX_CHANNELS = tpu_pkg::MaxChannelsDef,
  parameter int MAX_ROWS     = tpu_pkg::MaxRowsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         data_valid_i,
  input  logic                         data_stall_i,
  input  logic [7:0]                   data_byte_i,
  input  logic                         cell_valid_i,
  input  logic                         cell_stall_i,
  input  logic [7:0]                   note_i,
  input  logic [7:0]                   instrument_i,
  input  logic [7:0]                   volume_i,
  input  logic [7:0]                   effect_i,
  input  logic [7:0]                   effect_param_i,
  input  logic [4:0]                   channel_i,
  input  logic [7:0]                   row_i,
  input  logic                         last_cell_i,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  tpu_pkg::cfg_reg_e            cfg_index_i,
  input  logic [tpu_pkg::CfgDataW-1:0] cfg_data_i,
  output int                           mismatches_o,
  output int                           cells_owed_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import tpu_pkg::*;

  typedef struct packed {
    cell_t                fields;
    logic [ChanOutW-1:0]  channel;
    logic [RowOutW-1:0]   row;
    logic                 last_cell;
  } placed_cell_t;

  placed_cell_t            owed_cells[$];
  placed_cell_t            seen_cell;
  placed_cell_t            due_cell;
  logic [ChanCountW-1:0]   channel_count_q;
  logic [RowCountW-1:0]    row_count_q;
  phase_e                  phase_q;
  logic [MaskW-1:0]        fields_left;
  cell_t                   cell_acc;
  int                      channel_pos;
  int                      row_pos;

  function automatic int effective_count(int v, int maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return v;
  endfunction

  // Place the finished cell, then advance channel-first and wrap after the last cell.
  task automatic close_cell();
    int           chans;
    int           rows;
    bit           last_chan;
    bit           last_row;
    placed_cell_t c;
    chans     = effective_count(int'(channel_count_q), MAX_CHANNELS);
    rows      = effective_count(int'(row_count_q), MAX_ROWS);
    last_chan = (channel_pos + 1) >= chans;
    last_row  = (row_pos + 1) >= rows;
    c.fields  = cell_acc;
    if (cell_acc.note == NoteOffCode) begin
      c.fields.note = NoteOffOut;
    end
    c.channel   = ChanOutW'(channel_pos);
    c.row       = RowOutW'(row_pos);
    c.last_cell = last_chan && last_row;
    owed_cells = {owed_cells, c};
    if (last_chan) begin
      channel_pos = 0;
      row_pos     = last_row ? 0 : row_pos + 1;
    end else begin
      channel_pos = channel_pos + 1;
    end
    phase_q     = PH_LEAD;
    fields_left = '0;
  endtask

  task automatic take_byte(input logic [7:0] b);
    if (phase_q == PH_LEAD) begin
      cell_acc.note         = '0;
      cell_acc.instrument   = '0;
      cell_acc.volume       = VolumeDefault;
      cell_acc.effect       = '0;
      cell_acc.effect_param = '0;
      if (b[LeadFlagBit]) begin
        fields_left = b[MaskW-1:0];
      end else begin
        cell_acc.note = b;
        fields_left   = MaskAfterNote;
      end
      if (fields_left == '0) begin
        close_cell();
      end else begin
        phase_q = PH_FIELDS;
      end
    end else begin
      // fill the lowest field still owed, then clear its bit
      if (fields_left[0]) begin
        cell_acc.note = b;
      end else if (fields_left[1]) begin
        cell_acc.instrument = b;
      end else if (fields_left[2]) begin
        cell_acc.volume = b;
      end else if (fields_left[3]) begin
        cell_acc.effect = b;
      end else begin
        cell_acc.effect_param = b;
      end
      fields_left = fields_left & (fields_left - MaskW'(1));
      if (fields_left == '0) begin
        close_cell();
      end
    end
  endtask

  task automatic check_field(input string name, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      owed_cells.delete();
      channel_count_q = ChanCountReset;
      row_count_q     = RowCountReset;
      phase_q         = PH_LEAD;
      fields_left     = '0;
      cell_acc        = '0;
      channel_pos     = 0;
      row_pos         = 0;
      mismatches_o    = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_CHANNEL_COUNT: channel_count_q = cfg_data_i[ChanCountW-1:0];
          CFG_ROW_COUNT:     row_count_q     = cfg_data_i[RowCountW-1:0];
          default:           ;
        endcase
      end
      if (cell_valid_i && !cell_stall_i) begin
        seen_cell.fields.note         = note_i;
        seen_cell.fields.instrument   = instrument_i;
        seen_cell.fields.volume       = volume_i;
        seen_cell.fields.effect       = effect_i;
        seen_cell.fields.effect_param = effect_param_i;
        seen_cell.channel             = channel_i;
        seen_cell.row                 = row_i;
        seen_cell.last_cell           = last_cell_i;
        if (owed_cells.size() == 0) begin
          $error("unexpected cell: channel %0d row %0d", channel_i, row_i);
          mismatches_o++;
        end else begin
          due_cell = owed_cells.pop_front();
          check_field("note", due_cell.fields.note, seen_cell.fields.note);
          check_field("instrument", due_cell.fields.instrument, seen_cell.fields.instrument);
          check_field("volume", due_cell.fields.volume, seen_cell.fields.volume);
          check_field("effect", due_cell.fields.effect, seen_cell.fields.effect);
          check_field("effect_param", due_cell.fields.effect_param,
                      seen_cell.fields.effect_param);
          check_field("channel", ByteW'(due_cell.channel), ByteW'(seen_cell.channel));
          check_field("row", due_cell.row, seen_cell.row);
          check_field("last_cell", ByteW'(due_cell.last_cell), ByteW'(seen_cell.last_cell));
        end
      end
      if (data_valid_i && !data_stall_i) begin
        take_byte(data_byte_i);
      end
    end
    cells_owed_o <= owed_cells.size();
  end

endmodule

>>> verif/tracker_pattern_unpacker_unit_tb.sv
// Testbench top for tracker_pattern_unpacker_unit: clock, reset, byte and register
// stimulus with bursty sending and receiver stalls; pattern_cell_checker does the checking.
// Depends on tpu_pkg, pattern_cell_checker and the unit itself.
module tracker_pattern_unpacker_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tpu_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int PhaseCount  = 6;
  localparam int PhaseBytes  = 290;
  localparam int HoldOffLen  = 150;
  localparam int OpeningLen  = 22;

  typedef enum int {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HALF,
    STALL_HEAVY
  } stall_mode_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  data_valid_i = 1'b0;
  logic                  data_stall_o;
  logic [7:0]            data_byte_i = '0;
  logic                  cell_valid_o;
  logic                  cell_stall_i = 1'b0;
  logic [7:0]            note_o;
  logic [7:0]            instrument_o;
  logic [7:0]            volume_o;
  logic [7:0]            effect_o;
  logic [7:0]            effect_param_o;
  logic [4:0]            channel_o;
  logic [7:0]            row_o;
  logic                  last_cell_o;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  cfg_reg_e              cfg_index_i = CFG_CHANNEL_COUNT;
  logic [CfgDataW-1:0]   cfg_data_i = '0;

  int                    mismatches;
  int                    cells_owed;
  int                    bytes_sent = 0;
  int                    burst_left = 0;
  int                    cycle_count = 0;
  logic                  hold_off_req = 1'b0;

  tracker_pattern_unpacker_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_valid_i   (data_valid_i),
    .data_stall_o   (data_stall_o),
    .data_byte_i    (data_byte_i),
    .cell_valid_o   (cell_valid_o),
    .cell_stall_i   (cell_stall_i),
    .note_o         (note_o),
    .instrument_o   (instrument_o),
    .volume_o       (volume_o),
    .effect_o       (effect_o),
    .effect_param_o (effect_param_o),
    .channel_o      (channel_o),
    .row_o          (row_o),
    .last_cell_o    (last_cell_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  pattern_cell_checker u_cell_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .data_valid_i   (data_valid_i),
    .data_stall_i   (data_stall_o),
    .data_byte_i    (data_byte_i),
    .cell_valid_i   (cell_valid_o),
    .cell_stall_i   (cell_stall_i),
    .note_i         (note_o),
    .instrument_i   (instrument_o),
    .volume_i       (volume_o),
    .effect_i       (effect_o),
    .effect_param_i (effect_param_o),
    .channel_i      (channel_o),
    .row_i          (row_o),
    .last_cell_i    (last_cell_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_i    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .mismatches_o   (mismatches),
    .cells_owed_o   (cells_owed)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    forever begin
      @(posedge clk_i);
      cycle_count++;
      if (cycle_count > CycleLimit) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Cell receiver: runs of stall modes, plus one long hold-off on request.
  initial begin : cell_receiver
    int          run_len;
    int          k;
    stall_mode_e mode;
    bit          hold_done;
    hold_done = 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_off_req && !hold_done) begin
        hold_done = 1'b1;
        cell_stall_i <= 1'b1;
        repeat (HoldOffLen) @(posedge clk_i);
      end else begin
        run_len = $urandom_range(4, 60);
        mode    = stall_mode_e'($urandom_range(0, 3));
        for (k = 0; k < run_len; k++) begin
          case (mode)
            STALL_NONE:  cell_stall_i <= 1'b0;
            STALL_LIGHT: cell_stall_i <= ($urandom_range(0, 3) == 0);
            STALL_HALF:  cell_stall_i <= ($urandom_range(0, 1) == 1);
            default:     cell_stall_i <= ($urandom_range(0, 3) != 0);
          endcase
          @(posedge clk_i);
        end
      end
    end
  end

  // Offer one byte; open a new burst after a random gap when the current one is used up.
  task automatic put_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 5);
      burst_left = $urandom_range(1, 48);
      if (gap > 0) begin
        data_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    data_valid_i <= 1'b1;
    data_byte_i  <= b;
    do @(posedge clk_i); while (data_stall_o);
    bytes_sent++;
  endtask

  // Hold the byte side until every owed cell is out, then let a partial cell settle.
  task automatic wait_idle();
    data_valid_i <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (cells_owed != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgDataW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Mostly well-formed cells with random content; a few stray bytes break the alignment.
  task automatic send_random_cell();
    int         pick;
    int         k;
    logic [7:0] lead;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      lead = 8'($urandom_range(128, 255));
      put_byte(lead);
      for (k = 0; k < MaskW; k++) begin
        if (lead[k]) begin
          put_byte((k == 0 && $urandom_range(0, 3) == 0) ? NoteOffCode
                                                          : 8'($urandom_range(0, 255)));
        end
      end
    end else if (pick < 93) begin
      put_byte(($urandom_range(0, 4) == 0) ? NoteOffCode : 8'($urandom_range(0, 127)));
      repeat (4) put_byte(8'($urandom_range(0, 255)));
    end else begin
      repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin : stimulus
    logic [7:0]          opening_bytes [OpeningLen];
    logic [CfgDataW-1:0] chan_settings [PhaseCount];
    logic [CfgDataW-1:0] row_settings [PhaseCount];
    int                  p;
    int                  phase_end;
    bit                  paused;

    // empty mask, mask with only the ignored bits, full mask with note off,
    // plain note off, plain note zero, single volume, single parameter
    opening_bytes = '{8'h80, 8'hE0,
                      8'hFF, NoteOffCode, 8'hFF, 8'h00, 8'hAA, 8'h55,
                      NoteOffCode, 8'h01, 8'h40, 8'h0F, 8'hFF,
                      8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
                      8'h84, 8'h00,
                      8'hF0, 8'h33};
    chan_settings = '{9'd0, 9'd1, 9'h1FF, 9'd32, 9'd3, 9'd0};
    row_settings  = '{9'd0, 9'd1, 9'h1FF, 9'd256, 9'd5, 9'd0};
    chan_settings[PhaseCount-1] = CfgDataW'($urandom_range(0, 511));
    row_settings[PhaseCount-1]  = CfgDataW'($urandom_range(0, 511));
    paused = 1'b0;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CFG_CHANNEL_COUNT, 9'd3);
    write_reg(CFG_ROW_COUNT, 9'd2);
    foreach (opening_bytes[k]) put_byte(opening_bytes[k]);

    for (p = 0; p < PhaseCount; p++) begin
      wait_idle();
      write_reg(CFG_CHANNEL_COUNT, chan_settings[p]);
      write_reg(CFG_ROW_COUNT, row_settings[p]);
      if (p == 3) begin
        hold_off_req <= 1'b1;
      end
      phase_end = bytes_sent + PhaseBytes;
      while (bytes_sent < phase_end) begin
        if (p == 1 && !paused && bytes_sent >= phase_end - PhaseBytes / 2) begin
          paused = 1'b1;
          wait_idle();
        end
        send_random_cell();
      end
    end

    data_valid_i <= 1'b0;
    @(posedge clk_i);
    while (cells_owed != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    if (mismatches == 0 && cells_owed == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
